/* src/sorted_interval_set_insert_top_assert.svh */
// Assertion macros for the interval set block.
`ifndef SORTED_INTERVAL_SET_INSERT_TOP_ASSERT_SVH
`define SORTED_INTERVAL_SET_INSERT_TOP_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define SISI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sisi assertion failed");
// next-cycle implication
`define SISI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sisi assertion failed");
`else
`define SISI_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SISI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* src/sisi_pkg.sv */
package sisi_pkg;

    localparam int COORD_BITS = 16;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord start_pos;
        t_coord end_pos;
    } t_entry;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BAD_RANGE = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

endpackage

/* src/sisi_ram.sv */
// Simple dual-port entry RAM, one write and one registered read per cycle.
module sisi_ram
    import sisi_pkg::*;
#(
    parameter int AW = 5
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    localparam int DEPTH = 1 << AW;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/sorted_interval_set_insert_top.sv */
// Sorted interval set with insert-and-merge.
// Input channel: i_valid / o_stall carry one request (opcode, range, index).
// A request is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry one response per request
// (status, entry start/end, entry count after the request).
// From accept to o_valid: a clear, a no-op or an insert with start after end
// go straight to S_DONE, a read passes S_READ, and an insert walks every
// stored interval in S_SCAN and then S_TAIL; S_DONE loads the response once
// the response register is free. One request is in work at a time
// and the next is taken the cycle after a response is loaded; the insert is
// bound by the single read port of the entry RAM, which the merge walks
// one entry per cycle.
// The table lives in a ping-pong RAM: the merge reads the live bank and
// writes the merged table to the spare bank, then flips the bank on success,
// so a full table leaves the old contents untouched.
// Reset empties the table at once (count cleared); no clearing pass.
// The response register frees the input side: a new request may be taken
// while a response waits under i_stall; only the next response waits.
module sorted_interval_set_insert_top
    import sisi_pkg::*;
#(
    parameter int MAX_INTERVALS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [1:0]   i_opcode,
    input  logic [15:0]  i_range_start,
    input  logic [15:0]  i_range_end,
    input  logic [3:0]   i_read_index,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [1:0]   o_status,
    output logic [15:0]  o_entry_start,
    output logic [15:0]  o_entry_end,
    output logic [4:0]   o_entry_count
);

`include "sorted_interval_set_insert_top_assert.svh"

    localparam int IW = $clog2(MAX_INTERVALS);      // entry index
    localparam int CW = $clog2(MAX_INTERVALS + 1);  // count 0..MAX
    localparam int NW = $clog2(MAX_INTERVALS + 2);  // merged count 0..MAX+1
    localparam int AW = IW + 1;                     // bank + index

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_TAIL,
        S_DONE
    } t_state;

    // control
    t_state          r_state, n_state;
    logic            r_bank, n_bank;
    logic [CW-1:0]   r_count, n_count;
    logic            r_out_valid, n_out_valid;
    // request payload and merge context
    t_coord          r_s, n_s;
    t_coord          r_e, n_e;
    logic [3:0]      r_idx, n_idx;
    logic [CW-1:0]   r_ri, n_ri;
    logic            r_dv, n_dv;
    logic [NW-1:0]   r_n, n_n;
    logic            r_placed, n_placed;
    logic            r_hold, n_hold;
    t_entry          r_hent, n_hent;
    // pending response
    logic [1:0]      r_res_status, n_res_status;
    t_entry          r_res_entry, n_res_entry;
    // response register
    logic [1:0]      r_out_status, n_out_status;
    t_entry          r_out_entry, n_out_entry;
    logic [4:0]      r_out_count, n_out_count;

    logic            in_acc;
    logic            out_take;
    logic [AW-1:0]   rd_addr;
    t_entry          rd_data;
    logic            wr_req;
    logic            wr_en;
    t_entry          wr_data;
    logic [AW-1:0]   wr_addr;
    t_coord          os, oe;
    logic            cov_s, cov_e;
    logic [NW-1:0]   n_tail;

    assign in_acc   = i_valid && !o_stall;
    assign out_take = r_out_valid && !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    assign os    = rd_data.start_pos;
    assign oe    = rd_data.end_pos;
    assign cov_s = (os <= r_s) && (r_s <= oe);
    assign cov_e = (os <= r_e) && (r_e <= oe);

    // read the live bank: request index when idle, scan pointer otherwise
    assign rd_addr = (r_state == S_IDLE) ? {r_bank, IW'(i_read_index)}
                                         : {r_bank, r_ri[IW-1:0]};
    // merged entries go to the spare bank; slots past the table are dropped
    assign wr_addr = {~r_bank, r_n[IW-1:0]};
    assign wr_en   = wr_req && (32'(r_n) < MAX_INTERVALS);
    assign n_tail  = r_n + NW'(wr_req);

    always_comb begin
        n_state      = r_state;
        n_bank       = r_bank;
        n_count      = r_count;
        n_out_valid  = out_take ? 1'b0 : r_out_valid;
        n_s          = r_s;
        n_e          = r_e;
        n_idx        = r_idx;
        n_ri         = r_ri;
        n_dv         = r_dv;
        n_n          = r_n;
        n_placed     = r_placed;
        n_hold       = r_hold;
        n_hent       = r_hent;
        n_res_status = r_res_status;
        n_res_entry  = r_res_entry;
        n_out_status = r_out_status;
        n_out_entry  = r_out_entry;
        n_out_count  = r_out_count;
        wr_req       = 1'b0;
        wr_data      = rd_data;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_s          = i_range_start;
                    n_e          = i_range_end;
                    n_idx        = i_read_index;
                    n_res_status = ST_OK;
                    n_res_entry  = '0;
                    n_ri         = '0;
                    n_dv         = 1'b0;
                    n_n          = '0;
                    n_placed     = 1'b0;
                    n_hold       = 1'b0;
                    case (i_opcode)
                        OP_INSERT: begin
                            if (i_range_start > i_range_end) begin
                                n_res_status = ST_BAD_RANGE;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_READ: begin
                            n_state = S_READ;
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (32'(r_idx) < 32'(r_count)) begin
                    n_res_entry = rd_data;
                end else begin
                    n_res_status = ST_BAD_INDEX;
                end
                n_state = S_DONE;
            end
            S_SCAN: begin
                // issue pointer runs one ahead of the entry being merged
                n_dv = (r_ri < r_count);
                if (r_ri < r_count) begin
                    n_ri = r_ri + CW'(1);
                end
                if (r_dv) begin
                    if (r_placed) begin
                        // copy the rest, delayed by one when an entry is held
                        wr_req = 1'b1;
                        if (r_hold) begin
                            wr_data = r_hent;
                            n_hent  = rd_data;
                        end
                    end else if (r_e < os) begin
                        // new interval goes before this entry
                        wr_req   = 1'b1;
                        wr_data  = '{start_pos: r_s, end_pos: r_e};
                        n_hent   = rd_data;
                        n_hold   = 1'b1;
                        n_placed = 1'b1;
                    end else if (cov_s && cov_e) begin
                        wr_req   = 1'b1;
                        n_placed = 1'b1;
                    end else if (cov_s) begin
                        n_s = os;
                    end else if (cov_e) begin
                        wr_req   = 1'b1;
                        wr_data  = '{start_pos: r_s, end_pos: oe};
                        n_placed = 1'b1;
                    end else if (r_s > os) begin
                        wr_req = 1'b1;
                    end
                    if (wr_req) begin
                        n_n = r_n + NW'(1);
                    end
                end else if (r_ri == r_count) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                wr_req = !r_placed || r_hold;
                wr_data = r_placed ? r_hent : t_entry'{start_pos: r_s, end_pos: r_e};
                n_n = n_tail;
                if (32'(n_tail) > MAX_INTERVALS) begin
                    n_res_status = ST_FULL;
                end else begin
                    n_bank  = ~r_bank;
                    n_count = CW'(n_tail);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_entry  = r_res_entry;
                    n_out_count  = 5'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_s          <= n_s;
        r_e          <= n_e;
        r_idx        <= n_idx;
        r_ri         <= n_ri;
        r_dv         <= n_dv;
        r_n          <= n_n;
        r_placed     <= n_placed;
        r_hold       <= n_hold;
        r_hent       <= n_hent;
        r_res_status <= n_res_status;
        r_res_entry  <= n_res_entry;
        r_out_status <= n_out_status;
        r_out_entry  <= n_out_entry;
        r_out_count  <= n_out_count;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bank      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bank      <= n_bank;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    sisi_ram #(
        .AW (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_start = r_out_entry.start_pos;
    assign o_entry_end   = r_out_entry.end_pos;
    assign o_entry_count = r_out_count;

    // table never exceeds its capacity
    `SISI_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, 32'(r_count) <= MAX_INTERVALS)
    // the spare bank is written only while a merge is running
    `SISI_ASSERT_NOW(a_wr_in_merge, i_clk, i_rst_n, wr_en, (r_state == S_SCAN) || (r_state == S_TAIL))
    // the live bank flips only at the end of a merge
    `SISI_ASSERT_NEXT(a_bank_hold, i_clk, i_rst_n, r_state != S_TAIL, $stable(r_bank))
    // the count moves only at merge end or on a clear
    `SISI_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, (r_state != S_TAIL) && !(in_acc && (i_opcode == OP_CLEAR)), $stable(r_count))

endmodule
